/* design/sfrc_pkg.sv */
// ============================================================================
// sfrc_pkg - shared types and constants of the frame replay check
// status codes, register indexes, config and queue entry records
// ============================================================================
package sfrc_pkg;

    // frame length bounds
    localparam int FRAME_LIMIT    = 1024;
    localparam int FRAME_OVERHEAD = 48;

    // default replay window depth
    localparam int WINDOW_SIZE    = 64;

    // field widths
    localparam int SEQ_W      = 40;
    localparam int LEN_W      = 16;
    localparam int ID_W       = 16;
    localparam int PRINT_W    = 64;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    // entries in the queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // bytes 0 to 2 of the header
    localparam logic [23:0] MAGIC_WORD = 24'h4E5301;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_INVALID   = 3'd1,
        ST_UNAUTH    = 3'd2,
        ST_TOO_LARGE = 3'd3,
        ST_CONFLICT  = 3'd4,
        ST_AEAD      = 3'd5
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SESSION_READY = 3'd0,
        REG_LOCAL_ID      = 3'd1,
        REG_PEER_ID       = 3'd2,
        REG_OWN_DIRECTION = 3'd3,
        REG_PRINT_HIGH    = 3'd4,
        REG_PRINT_LOW     = 3'd5
    } reg_index_t;

    typedef struct packed {
        logic               session_ready;
        logic [ID_W-1:0]    local_id;
        logic [ID_W-1:0]    peer_id;
        logic               own_direction;
        logic [PRINT_W-1:0] print_high;
        logic [PRINT_W-1:0] print_low;
    } cfg_t;

    // classified word handed from front to back
    typedef struct packed {
        status_t          pre_status;
        logic [SEQ_W-1:0] seq;
        logic [LEN_W-1:0] size;
        logic             aead_ok;
    } item_t;

endpackage

/* design/sfrc_front.sv */
// ============================================================================
// sfrc_front - header classification
// stateless checks of one header against the session settings
// ============================================================================
module sfrc_front (
    input  sfrc_pkg::cfg_t                  cfg,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic                            s_expected_channel,
    input  logic [sfrc_pkg::LEN_W-1:0]      s_frame_length,
    input  logic [31:0]                     s_header_first_word,
    input  logic [sfrc_pkg::ID_W-1:0]       s_header_source,
    input  logic [sfrc_pkg::ID_W-1:0]       s_header_dest,
    input  logic [sfrc_pkg::PRINT_W-1:0]    s_header_print_high,
    input  logic [sfrc_pkg::PRINT_W-1:0]    s_header_print_low,
    input  logic [sfrc_pkg::SEQ_W-1:0]      s_header_sequence,
    input  logic [sfrc_pkg::LEN_W-1:0]      s_header_size,
    input  logic [7:0]                      s_header_channel,
    input  logic [sfrc_pkg::LEN_W-1:0]      s_receive_capacity,
    input  logic                            s_aead_ok,
    input  logic                            q_full,
    output logic                            q_push,
    output sfrc_pkg::item_t                 q_item
);

    logic                       bad_length;
    logic                       bad_frame;
    logic                       bad_auth;
    logic [sfrc_pkg::LEN_W-1:0] body_len;

    assign s_ready = !q_full;
    assign q_push  = s_valid && !q_full;

    always_comb begin
        bad_length = (s_frame_length <= sfrc_pkg::LEN_W'(sfrc_pkg::FRAME_OVERHEAD)) ||
                     (s_frame_length >  sfrc_pkg::LEN_W'(sfrc_pkg::FRAME_LIMIT));
        bad_frame  = (s_header_first_word[31:8] != sfrc_pkg::MAGIC_WORD) ||
                     (s_header_channel != {7'd0, s_expected_channel});
        bad_auth   = (s_header_first_word[7:0] != {7'd0, ~cfg.own_direction}) ||
                     (s_header_source != cfg.peer_id) ||
                     (s_header_dest != cfg.local_id) ||
                     (s_header_print_high != cfg.print_high) ||
                     (s_header_print_low != cfg.print_low);
        // only meaningful once the length is above the overhead
        body_len   = s_frame_length - sfrc_pkg::LEN_W'(sfrc_pkg::FRAME_OVERHEAD);

        if (!cfg.session_ready || bad_length || bad_frame) begin
            q_item.pre_status = sfrc_pkg::ST_INVALID;
        end else if (bad_auth) begin
            q_item.pre_status = sfrc_pkg::ST_UNAUTH;
        end else if (s_header_size != body_len) begin
            q_item.pre_status = sfrc_pkg::ST_INVALID;
        end else if (s_receive_capacity < s_header_size) begin
            q_item.pre_status = sfrc_pkg::ST_TOO_LARGE;
        end else begin
            q_item.pre_status = sfrc_pkg::ST_OK;
        end
        q_item.seq     = s_header_sequence;
        q_item.size    = s_header_size;
        q_item.aead_ok = s_aead_ok;
    end

endmodule

/* design/sfrc_fifo.sv */
// ============================================================================
// sfrc_fifo - queue of classified words
// small register queue that decouples the front from the window logic
// ============================================================================
module sfrc_fifo (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  sfrc_pkg::item_t push_item,
    input  logic            pop,
    output sfrc_pkg::item_t head_item,
    output logic            full,
    output logic            empty
);

    localparam int DEPTH = sfrc_pkg::QUEUE_DEPTH;
    localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = $clog2(DEPTH + 1);

    sfrc_pkg::item_t entry_reg [DEPTH];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   count_reg, count_next;

    assign full      = (count_reg == CW'(DEPTH));
    assign empty     = (count_reg == '0);
    assign head_item = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

/* design/sfrc_back.sv */
// ============================================================================
// sfrc_back - replay window and result register
// checks the counter against the sliding window, updates it, drives results
// ============================================================================
module sfrc_back #(
    parameter int WINDOW_SIZE = sfrc_pkg::WINDOW_SIZE
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       q_empty,
    input  sfrc_pkg::item_t            head_item,
    output logic                       q_pop,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [2:0]                 m_status,
    output logic [sfrc_pkg::LEN_W-1:0] m_payload_length
);

    localparam int SW = sfrc_pkg::SEQ_W;
    localparam int IW = (WINDOW_SIZE > 1) ? $clog2(WINDOW_SIZE) : 1;
    localparam logic [WINDOW_SIZE-1:0] MARK_ONE = WINDOW_SIZE'(1);

    logic [SW-1:0]          top_reg, top_next;
    logic [WINDOW_SIZE-1:0] marks_reg, marks_next;
    logic                   m_valid_reg, m_valid_next;
    sfrc_pkg::status_t      m_status_reg;
    logic [sfrc_pkg::LEN_W-1:0] m_len_reg;

    logic                   win_empty;
    logic                   above;
    logic [SW-1:0]          dist_up;
    logic [SW-1:0]          dist_down;
    logic                   far_up;
    logic                   far_down;
    logic [WINDOW_SIZE-1:0] marks_down;
    logic                   conflict;
    sfrc_pkg::status_t      status;

    assign q_pop = !q_empty && (!m_valid_reg || m_ready);

    always_comb begin
        win_empty  = (marks_reg == '0);
        above      = (head_item.seq > top_reg);
        dist_up    = head_item.seq - top_reg;
        dist_down  = top_reg - head_item.seq;
        far_up     = (dist_up >= SW'(WINDOW_SIZE));
        far_down   = (dist_down >= SW'(WINDOW_SIZE));
        marks_down = marks_reg >> dist_down[IW-1:0];
        conflict   = !win_empty && !above && (far_down || marks_down[0]);

        if (head_item.pre_status != sfrc_pkg::ST_OK) begin
            status = head_item.pre_status;
        end else if (conflict) begin
            status = sfrc_pkg::ST_CONFLICT;
        end else if (!head_item.aead_ok) begin
            status = sfrc_pkg::ST_AEAD;
        end else begin
            status = sfrc_pkg::ST_OK;
        end

        top_next   = top_reg;
        marks_next = marks_reg;
        if (q_pop && status == sfrc_pkg::ST_OK) begin
            if (win_empty) begin
                marks_next = MARK_ONE;
                top_next   = head_item.seq;
            end else if (above) begin
                marks_next = far_up ? MARK_ONE
                                    : ((marks_reg << dist_up[IW-1:0]) | MARK_ONE);
                top_next   = head_item.seq;
            end else begin
                marks_next = marks_reg | (MARK_ONE << dist_down[IW-1:0]);
            end
        end

        m_valid_next = m_valid_reg;
        if (q_pop) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            top_reg     <= '0;
            marks_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            top_reg     <= top_next;
            marks_reg   <= marks_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            m_status_reg <= status;
            m_len_reg    <= (status == sfrc_pkg::ST_OK) ? head_item.size : '0;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_status         = m_status_reg;
    assign m_payload_length = m_len_reg;

endmodule

/* design/secure_frame_replay_check_top.sv */
// ============================================================================
// secure_frame_replay_check_top - receive header check with replay window
// path: an accepted word is written into the queue; the back pops it when the result
// register is free and registers its status and length from combinational logic
// throughput: one word per cycle while m_ready is high
// reset: config returns to defaults, replay window empty, queue and output empty
// ============================================================================
module secure_frame_replay_check_top #(
    parameter int WINDOW_SIZE = sfrc_pkg::WINDOW_SIZE
) (
    input  logic                            aclk,
    input  logic                            aresetn,

    // configuration write channel
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [sfrc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [sfrc_pkg::CFG_DATA_W-1:0] cfg_data,

    // header input channel
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic                            s_expected_channel,
    input  logic [sfrc_pkg::LEN_W-1:0]      s_frame_length,
    input  logic [31:0]                     s_header_first_word,
    input  logic [sfrc_pkg::ID_W-1:0]       s_header_source,
    input  logic [sfrc_pkg::ID_W-1:0]       s_header_dest,
    input  logic [sfrc_pkg::PRINT_W-1:0]    s_header_print_high,
    input  logic [sfrc_pkg::PRINT_W-1:0]    s_header_print_low,
    input  logic [sfrc_pkg::SEQ_W-1:0]      s_header_sequence,
    input  logic [sfrc_pkg::LEN_W-1:0]      s_header_size,
    input  logic [7:0]                      s_header_channel,
    input  logic [sfrc_pkg::LEN_W-1:0]      s_receive_capacity,
    input  logic                            s_aead_ok,

    // result channel
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [2:0]                      m_status,
    output logic [sfrc_pkg::LEN_W-1:0]      m_payload_length
);

    // session settings, to be written only while idle; the block does not enforce it
    sfrc_pkg::cfg_t  cfg_reg, cfg_next;

    // front to queue
    logic            q_push;
    sfrc_pkg::item_t q_item;

    // queue to back
    logic            q_pop;
    logic            q_full;
    logic            q_empty;
    sfrc_pkg::item_t q_head;

    // config writes are always taken
    assign cfg_ready = 1'b1;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (sfrc_pkg::reg_index_t'(cfg_index))
                sfrc_pkg::REG_SESSION_READY: cfg_next.session_ready = cfg_data[0];
                sfrc_pkg::REG_LOCAL_ID:      cfg_next.local_id = cfg_data[sfrc_pkg::ID_W-1:0];
                sfrc_pkg::REG_PEER_ID:       cfg_next.peer_id = cfg_data[sfrc_pkg::ID_W-1:0];
                sfrc_pkg::REG_OWN_DIRECTION: cfg_next.own_direction = cfg_data[0];
                sfrc_pkg::REG_PRINT_HIGH:    cfg_next.print_high = cfg_data;
                sfrc_pkg::REG_PRINT_LOW:     cfg_next.print_low = cfg_data;
                default: begin
                    // unknown index, write dropped
                    cfg_next = cfg_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.session_ready <= 1'b0;
            cfg_reg.local_id      <= sfrc_pkg::ID_W'(1);
            cfg_reg.peer_id       <= sfrc_pkg::ID_W'(2);
            cfg_reg.own_direction <= 1'b0;
            cfg_reg.print_high    <= '0;
            cfg_reg.print_low     <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // front: classify the header, no state of its own
    sfrc_front u_front (
        .cfg                 (cfg_reg),
        .s_valid             (s_valid),
        .s_ready             (s_ready),
        .s_expected_channel  (s_expected_channel),
        .s_frame_length      (s_frame_length),
        .s_header_first_word (s_header_first_word),
        .s_header_source     (s_header_source),
        .s_header_dest       (s_header_dest),
        .s_header_print_high (s_header_print_high),
        .s_header_print_low  (s_header_print_low),
        .s_header_sequence   (s_header_sequence),
        .s_header_size       (s_header_size),
        .s_header_channel    (s_header_channel),
        .s_receive_capacity  (s_receive_capacity),
        .s_aead_ok           (s_aead_ok),
        .q_full              (q_full),
        .q_push              (q_push),
        .q_item              (q_item)
    );

    // queue: lets the front keep taking words while the result side stalls, until it is full
    sfrc_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_item (q_item),
        .pop       (q_pop),
        .head_item (q_head),
        .full      (q_full),
        .empty     (q_empty)
    );

    // back: replay window check and update, result register
    sfrc_back #(
        .WINDOW_SIZE (WINDOW_SIZE)
    ) u_back (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .q_empty          (q_empty),
        .head_item        (q_head),
        .q_pop            (q_pop),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_status         (m_status),
        .m_payload_length (m_payload_length)
    );

    // an accepted word is in the queue on the next cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !q_empty)
        else $error("accepted word missing from queue");

    // a closed session classifies every word as invalid
    assert property (@(posedge aclk) disable iff (!aresetn)
        (q_push && !cfg_reg.session_ready) |-> (q_item.pre_status == sfrc_pkg::ST_INVALID))
        else $error("word passed with session closed");

    // an accepted frame always carries plaintext past the overhead
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status == sfrc_pkg::ST_OK) |-> (m_payload_length != '0))
        else $error("ok result with empty payload");

    // a rejected frame reports no payload
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status != sfrc_pkg::ST_OK) |-> (m_payload_length == '0))
        else $error("rejected result with payload length");

endmodule

/* tb/secure_frame_replay_check_top_test.sv */
// ============================================================================
// secure_frame_replay_check_top_test - header checks and anti-replay window
// sends frame header words against a shadow copy of the session registers and
// of the 64-deep replay window, and checks every status word in arrival order
// ============================================================================
module secure_frame_replay_check_top_test;

    import sfrc_pkg::*;

    // no-progress limit, far above the longest random stall
    localparam int WATCHDOG_LIMIT = 4000;
    // settle time after the last result
    localparam int DRAIN_CYCLES   = 8;
    localparam int MAX_SIZE       = FRAME_LIMIT - FRAME_OVERHEAD;

    // index past the register list, the block must ignore it
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd6;
    localparam logic [SEQ_W-1:0]     SEQ_MAX   = '1;
    localparam logic [63:0]          WINDOW_MASK =
        (WINDOW_SIZE >= 64) ? '1 : ((64'd1 << WINDOW_SIZE) - 64'd1);

    // one frame header word as driven on the s_ ports
    typedef struct {
        logic               expected_channel;
        logic [LEN_W-1:0]   frame_length;
        logic [31:0]        first_word;
        logic [ID_W-1:0]    source;
        logic [ID_W-1:0]    dest;
        logic [PRINT_W-1:0] print_high;
        logic [PRINT_W-1:0] print_low;
        logic [SEQ_W-1:0]   seq_num;
        logic [LEN_W-1:0]   hdr_size;
        logic [7:0]         channel;
        logic [LEN_W-1:0]   capacity;
        logic               aead_ok;
    } header_t;

    typedef struct {
        status_t          status;
        logic [LEN_W-1:0] payload_length;
    } verdict_t;

    // ways to spoil an otherwise good header
    typedef enum int {
        BREAK_LENGTH_LOW,
        BREAK_LENGTH_HIGH,
        BREAK_MAGIC,
        BREAK_CHANNEL,
        BREAK_DIRECTION,
        BREAK_SOURCE,
        BREAK_DEST,
        BREAK_PRINT_HIGH,
        BREAK_PRINT_LOW,
        BREAK_SIZE,
        BREAK_CAPACITY,
        BREAK_AEAD
    } flaw_t;

    // block ports, every input known from time zero
    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic                  s_expected_channel = 1'b0;
    logic [LEN_W-1:0]      s_frame_length = '0;
    logic [31:0]           s_header_first_word = '0;
    logic [ID_W-1:0]       s_header_source = '0;
    logic [ID_W-1:0]       s_header_dest = '0;
    logic [PRINT_W-1:0]    s_header_print_high = '0;
    logic [PRINT_W-1:0]    s_header_print_low = '0;
    logic [SEQ_W-1:0]      s_header_sequence = '0;
    logic [LEN_W-1:0]      s_header_size = '0;
    logic [7:0]            s_header_channel = '0;
    logic [LEN_W-1:0]      s_receive_capacity = '0;
    logic                  s_aead_ok = 1'b0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic [2:0]            m_status;
    logic [LEN_W-1:0]      m_payload_length;

    // shadow of the session registers and the replay window
    cfg_t             session_cfg;
    logic [SEQ_W-1:0] replay_top;
    logic [63:0]      replay_marks;

    // status words still owed by the block, oldest first
    verdict_t pending_verdicts[$];

    int send_idle_pct = 0;
    int stall_pct     = 0;
    int error_count   = 0;
    int quiet_cycles  = 0;

    secure_frame_replay_check_top dut (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .cfg_valid           (cfg_valid),
        .cfg_ready           (cfg_ready),
        .cfg_index           (cfg_index),
        .cfg_data            (cfg_data),
        .s_valid             (s_valid),
        .s_ready             (s_ready),
        .s_expected_channel  (s_expected_channel),
        .s_frame_length      (s_frame_length),
        .s_header_first_word (s_header_first_word),
        .s_header_source     (s_header_source),
        .s_header_dest       (s_header_dest),
        .s_header_print_high (s_header_print_high),
        .s_header_print_low  (s_header_print_low),
        .s_header_sequence   (s_header_sequence),
        .s_header_size       (s_header_size),
        .s_header_channel    (s_header_channel),
        .s_receive_capacity  (s_receive_capacity),
        .s_aead_ok           (s_aead_ok),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_status            (m_status),
        .m_payload_length    (m_payload_length)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // ------------------------------------------------------------------------
    // predictor: classify one accepted header and move the replay window
    // ------------------------------------------------------------------------
    function automatic verdict_t judge_frame(input header_t h);
        status_t          st;
        logic [SEQ_W-1:0] gap;
        verdict_t         v;
        st = ST_OK;
        if (!session_cfg.session_ready)
            st = ST_INVALID;
        else if (h.frame_length <= FRAME_OVERHEAD || h.frame_length > FRAME_LIMIT)
            st = ST_INVALID;
        else if (h.first_word[31:8] != MAGIC_WORD || h.channel != {7'd0, h.expected_channel})
            st = ST_INVALID;
        else if (h.first_word[7:0] != {7'd0, ~session_cfg.own_direction} ||
                 h.source != session_cfg.peer_id || h.dest != session_cfg.local_id ||
                 h.print_high != session_cfg.print_high ||
                 h.print_low != session_cfg.print_low)
            st = ST_UNAUTH;
        else if (int'(h.hdr_size) != int'(h.frame_length) - FRAME_OVERHEAD)
            st = ST_INVALID;
        else if (h.capacity < h.hdr_size)
            st = ST_TOO_LARGE;
        else if (replay_marks != '0 && h.seq_num <= replay_top) begin
            // at or below the top: too old, or already seen
            gap = replay_top - h.seq_num;
            if (gap >= WINDOW_SIZE)
                st = ST_CONFLICT;
            else if (replay_marks[gap[5:0]])
                st = ST_CONFLICT;
        end

        if (st == ST_OK && !h.aead_ok)
            st = ST_AEAD;

        // only a fully accepted frame touches the window
        if (st == ST_OK) begin
            if (replay_marks == '0) begin
                replay_marks = 64'd1;
                replay_top   = h.seq_num;
            end else if (h.seq_num > replay_top) begin
                gap = h.seq_num - replay_top;
                if (gap >= WINDOW_SIZE)
                    replay_marks = 64'd1;
                else
                    replay_marks = ((replay_marks << gap) | 64'd1) & WINDOW_MASK;
                replay_top = h.seq_num;
            end else begin
                gap = replay_top - h.seq_num;
                replay_marks[gap[5:0]] = 1'b1;
                replay_marks = replay_marks & WINDOW_MASK;
            end
        end

        v.status         = st;
        v.payload_length = (st == ST_OK) ? h.hdr_size : '0;
        return v;
    endfunction

    // ------------------------------------------------------------------------
    // header builders
    // ------------------------------------------------------------------------

    // header that passes every check of the current session
    function automatic header_t make_frame(input logic [SEQ_W-1:0] seq,
                                           input logic [LEN_W-1:0] plain_len);
        header_t h;
        h.expected_channel = 1'($urandom_range(1, 0));
        h.frame_length     = plain_len + LEN_W'(FRAME_OVERHEAD);
        h.first_word       = {MAGIC_WORD, 7'd0, ~session_cfg.own_direction};
        h.source           = session_cfg.peer_id;
        h.dest             = session_cfg.local_id;
        h.print_high       = session_cfg.print_high;
        h.print_low        = session_cfg.print_low;
        h.seq_num          = seq;
        h.hdr_size         = plain_len;
        h.channel          = {7'd0, h.expected_channel};
        h.capacity         = 16'hFFFF;
        h.aead_ok          = 1'b1;
        return h;
    endfunction

    function automatic header_t apply_flaw(input header_t h, input flaw_t f);
        case (f)
            BREAK_LENGTH_LOW:  h.frame_length = LEN_W'($urandom_range(FRAME_OVERHEAD, 0));
            BREAK_LENGTH_HIGH: h.frame_length = LEN_W'($urandom_range(65535, FRAME_LIMIT + 1));
            BREAK_MAGIC:       h.first_word[31:8] = h.first_word[31:8] ^
                                                    (24'd1 << $urandom_range(23, 0));
            BREAK_CHANNEL:     h.channel = h.channel ^ (8'd1 << $urandom_range(7, 0));
            BREAK_DIRECTION:   h.first_word[7:0] = h.first_word[7:0] ^
                                                   (8'd1 << $urandom_range(7, 0));
            BREAK_SOURCE:      h.source = h.source ^ (16'd1 << $urandom_range(15, 0));
            BREAK_DEST:        h.dest = h.dest ^ (16'd1 << $urandom_range(15, 0));
            BREAK_PRINT_HIGH:  h.print_high = h.print_high ^ (64'd1 << $urandom_range(63, 0));
            BREAK_PRINT_LOW:   h.print_low = h.print_low ^ (64'd1 << $urandom_range(63, 0));
            BREAK_SIZE:        h.hdr_size = h.hdr_size + LEN_W'($urandom_range(100, 1));
            BREAK_CAPACITY:    h.capacity = LEN_W'($urandom_range(h.hdr_size - 1, 0));
            default:           h.aead_ok = 1'b0;
        endcase
        return h;
    endfunction

    // counter near the window: fresh, old (in or just past the window), duplicate or a jump
    function automatic logic [SEQ_W-1:0] pick_seq();
        int unsigned back;
        back = $urandom_range(70, 0);
        case ($urandom_range(9, 0))
            0, 1, 2, 3: return replay_top + $urandom_range(8, 1);
            4, 5, 6:    return (replay_top >= back) ? replay_top - back : replay_top + 1;
            7:          return replay_top + $urandom_range(300, 9);
            default:    return replay_top;
        endcase
    endfunction

    function automatic header_t random_frame();
        header_t          h;
        int               pick;
        logic [LEN_W-1:0] plain_len;
        pick      = $urandom_range(99, 0);
        plain_len = LEN_W'($urandom_range(MAX_SIZE, 1));
        h         = make_frame(pick_seq(), plain_len);
        if (pick < 70) begin
            // well-formed, mostly aimed at the replay window
            if ($urandom_range(9, 0) == 0)
                h.aead_ok = 1'b0;
            if ($urandom_range(4, 0) == 0)
                h.capacity = LEN_W'($urandom_range(65535, plain_len));
        end else if (pick < 85) begin
            h = apply_flaw(h, flaw_t'($urandom_range(BREAK_AEAD, BREAK_LENGTH_LOW)));
        end else begin
            // pure noise on every field
            h.expected_channel = 1'($urandom_range(1, 0));
            h.frame_length     = LEN_W'($urandom_range(65535, 0));
            h.first_word       = $urandom;
            h.source           = ID_W'($urandom_range(65535, 0));
            h.dest             = ID_W'($urandom_range(65535, 0));
            h.print_high       = {$urandom, $urandom};
            h.print_low        = {$urandom, $urandom};
            h.seq_num          = {8'($urandom_range(255, 0)), 32'($urandom)};
            h.hdr_size         = LEN_W'($urandom_range(65535, 0));
            h.channel          = 8'($urandom_range(255, 0));
            h.capacity         = LEN_W'($urandom_range(65535, 0));
            h.aead_ok          = 1'($urandom_range(1, 0));
        end
        return h;
    endfunction

    // ------------------------------------------------------------------------
    // channel tasks
    // ------------------------------------------------------------------------

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t: %s", $realtime, what);
        error_count++;
    endtask

    // cfg_valid stays high so back-to-back writes need no gap
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready)
            @(posedge aclk);
        case (idx)
            REG_SESSION_READY: session_cfg.session_ready = value[0];
            REG_LOCAL_ID:      session_cfg.local_id      = value[ID_W-1:0];
            REG_PEER_ID:       session_cfg.peer_id       = value[ID_W-1:0];
            REG_OWN_DIRECTION: session_cfg.own_direction = value[0];
            REG_PRINT_HIGH:    session_cfg.print_high    = value;
            REG_PRINT_LOW:     session_cfg.print_low     = value;
            default: ;
        endcase
    endtask

    // full register set plus a write to an unused index, block must be idle
    task automatic open_session(input logic ready, input logic [ID_W-1:0] local_addr,
                                input logic [ID_W-1:0] peer_addr, input logic dir,
                                input logic [PRINT_W-1:0] ph, input logic [PRINT_W-1:0] pl);
        write_reg(REG_SESSION_READY, {63'd0, ready});
        write_reg(REG_LOCAL_ID, {48'd0, local_addr});
        write_reg(REG_PEER_ID, {48'd0, peer_addr});
        write_reg(REG_OWN_DIRECTION, {63'd0, dir});
        write_reg(REG_PRINT_HIGH, ph);
        write_reg(REG_PRINT_LOW, pl);
        write_reg(REG_SPARE, {$urandom, $urandom});
        cfg_valid <= 1'b0;
    endtask

    task automatic send_frame(input header_t h);
        while ($urandom_range(99, 0) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid             <= 1'b1;
        s_expected_channel  <= h.expected_channel;
        s_frame_length      <= h.frame_length;
        s_header_first_word <= h.first_word;
        s_header_source     <= h.source;
        s_header_dest       <= h.dest;
        s_header_print_high <= h.print_high;
        s_header_print_low  <= h.print_low;
        s_header_sequence   <= h.seq_num;
        s_header_size       <= h.hdr_size;
        s_header_channel    <= h.channel;
        s_receive_capacity  <= h.capacity;
        s_aead_ok           <= h.aead_ok;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        // accepted at this edge, the window moves in acceptance order
        pending_verdicts.push_back(judge_frame(h));
    endtask

    // stop sending and wait for every owed status word
    task automatic drain_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_verdicts.size() != 0)
            @(posedge aclk);
    endtask

    // ------------------------------------------------------------------------
    // result side: random back-pressure and in-order compare
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin : result_check
        verdict_t want;
        m_ready <= ($urandom_range(99, 0) >= stall_pct);
        if (aresetn && m_valid && m_ready) begin
            if (pending_verdicts.size() == 0) begin
                report_mismatch($sformatf("result word with nothing expected, status %0d",
                                          m_status));
            end else begin
                want = pending_verdicts.pop_front();
                if (m_status !== want.status)
                    report_mismatch($sformatf("status %0d, expected %s",
                                              m_status, want.status.name()));
                if (m_payload_length !== want.payload_length)
                    report_mismatch($sformatf("payload_length %0d, expected %0d",
                                              m_payload_length, want.payload_length));
            end
        end
    end

    // no handshake on any channel while something is outstanding
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready) ||
            !(s_valid || cfg_valid || pending_verdicts.size() != 0)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    // session still closed after reset: everything is invalid
    task automatic test_closed_session();
        header_t h;
        send_frame(make_frame(40'd5, 16'd1));
        h = make_frame(SEQ_MAX, LEN_W'(MAX_SIZE));
        h.expected_channel = 1'b1;
        h.channel          = 8'd1;
        send_frame(h);
        drain_results();
    endtask

    // open the session only, ids and fingerprint keep their reset values;
    // counter zero into the empty window
    task automatic test_default_session();
        write_reg(REG_SESSION_READY, 64'd1);
        cfg_valid <= 1'b0;
        send_frame(make_frame(40'd0, 16'd16));
        drain_results();
    endtask

    // length bounds and each header check in turn, extreme register values
    task automatic test_header_checks();
        header_t h;
        open_session(1'b1, 16'hFFFE, 16'h0001, 1'b1, '1, '0);

        // smallest payload, capacity exactly fits
        h = make_frame(replay_top + 1, 16'd1);
        h.capacity = 16'd1;
        send_frame(h);
        // largest frame
        send_frame(make_frame(replay_top + 1, LEN_W'(MAX_SIZE)));
        // length just at the overhead, and one past the limit
        h = make_frame(replay_top + 1, 16'd1);
        h.frame_length = LEN_W'(FRAME_OVERHEAD);
        send_frame(h);
        h = make_frame(replay_top + 1, LEN_W'(MAX_SIZE));
        h.frame_length = LEN_W'(FRAME_LIMIT + 1);
        send_frame(h);

        for (int f = BREAK_MAGIC; f <= BREAK_AEAD; f++) begin
            h = make_frame(replay_top + 1, LEN_W'($urandom_range(MAX_SIZE, 1)));
            // failed decrypt on the top counter value leaves the window alone
            if (flaw_t'(f) == BREAK_AEAD)
                h.seq_num = SEQ_MAX;
            send_frame(apply_flaw(h, flaw_t'(f)));
        end
        drain_results();
    endtask

    // window edges: jump clear, duplicate, oldest slot, just outside,
    // shift keeping the oldest mark, decrypt failure not marking
    task automatic test_replay_window();
        header_t          h;
        logic [SEQ_W-1:0] base;
        base = replay_top + 100;
        send_frame(make_frame(base, 16'd8));
        send_frame(make_frame(base, 16'd8));
        send_frame(make_frame(base - (WINDOW_SIZE - 1), 16'd8));
        send_frame(make_frame(base - WINDOW_SIZE, 16'd8));
        send_frame(make_frame(base - (WINDOW_SIZE - 1), 16'd8));
        send_frame(make_frame(base + (WINDOW_SIZE - 1), 16'd8));
        send_frame(make_frame(base, 16'd8));
        h = make_frame(base + WINDOW_SIZE, 16'd8);
        h.aead_ok = 1'b0;
        send_frame(h);
        h.aead_ok = 1'b1;
        send_frame(h);
        drain_results();
    endtask

    task automatic test_random_traffic(input int frames);
        open_session(1'b1, ID_W'($urandom_range(65534, 1)), ID_W'($urandom_range(65534, 1)),
                     1'($urandom_range(1, 0)), {$urandom, $urandom}, {$urandom, $urandom});
        repeat (frames)
            send_frame(random_frame());
        drain_results();
    endtask

    task automatic test_closed_traffic(input int frames);
        open_session(1'b0, ID_W'($urandom_range(65534, 1)), ID_W'($urandom_range(65534, 1)),
                     1'($urandom_range(1, 0)), {$urandom, $urandom}, {$urandom, $urandom});
        repeat (frames)
            send_frame(random_frame());
        drain_results();
    endtask

    initial begin
        // shadow starts at the reset values
        session_cfg.session_ready = 1'b0;
        session_cfg.local_id      = 16'd1;
        session_cfg.peer_id       = 16'd2;
        session_cfg.own_direction = 1'b0;
        session_cfg.print_high    = '0;
        session_cfg.print_low     = '0;
        replay_top                = '0;
        replay_marks              = '0;

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // sender idles lightly, receiver stalls heavily
        send_idle_pct = 24;
        stall_pct     = 49;
        test_closed_session();
        test_default_session();
        test_header_checks();
        test_replay_window();
        test_random_traffic(400);

        // the other way round
        send_idle_pct = 49;
        stall_pct     = 24;
        test_closed_traffic(50);
        test_random_traffic(400);

        // full rate both sides
        send_idle_pct = 0;
        stall_pct     = 0;
        test_random_traffic(400);

        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (error_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

/* sim.f */
design/sfrc_pkg.sv
design/sfrc_front.sv
design/sfrc_fifo.sv
design/sfrc_back.sv
design/secure_frame_replay_check_top.sv
tb/secure_frame_replay_check_top_test.sv
